// ===== rtl/cpo_pkg.sv =====
`timescale 1ns / 1ps

package cpo_pkg;

   // width of the coordinate fields on the request ports
   localparam int FIELD_BITS = 16;

   // defaults for the top-level parameters
   localparam int DEF_MAX_VERTS  = 16;
   localparam int DEF_COORD_BITS = 16;

   // fewest vertices that still make a polygon
   localparam int MIN_POLY_VERTS = 3;

   // response status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_SHORT    = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   // shared arithmetic unit operations
   typedef logic alu_op_type;
   localparam alu_op_type ALU_SUB = 1'b0;
   localparam alu_op_type ALU_MUL = 1'b1;

endpackage

// ===== rtl/convex_polygon_overlap_test.sv =====
`timescale 1ns / 1ps
// Vertex requests without last leave busy low, so the next may follow at once.
// A request with last runs the axis test; each projected vertex steps through the read,
// multiply x, multiply y, subtract and compare states, with the one shared multiply/subtract
// unit doing the middle three. Short or overflowed pairs answer in the cycle after the request.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Synchronous reset clears the counts, overflow flag and sequencer; vertex stores are not cleared.

module convex_polygon_overlap_test #(
   parameter int MAX_VERTS  = cpo_pkg::DEF_MAX_VERTS,
   parameter int COORD_BITS = cpo_pkg::DEF_COORD_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_cmd,
   input  logic signed [cpo_pkg::FIELD_BITS-1:0]  req_x_coord,
   input  logic signed [cpo_pkg::FIELD_BITS-1:0]  req_y_coord,
   input  logic                                   req_last,
   output logic                                   rsp_strobe,
   output logic                                   rsp_overlap,
   output cpo_pkg::status_type                    rsp_status
);

   import cpo_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int DW   = CW + 1;
   localparam int W    = 2 * CW + 2;
   localparam int AW   = $clog2(MAX_VERTS);
   localparam int CNTW = $clog2(MAX_VERTS + 1);
   localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_VERTS);
   localparam logic [CNTW-1:0] CNT_MIN = CNTW'(MIN_POLY_VERTS);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_E_RDI = 4'd1;
   localparam logic [3:0] S_E_RDJ = 4'd2;
   localparam logic [3:0] S_E_DX  = 4'd3;
   localparam logic [3:0] S_E_DY  = 4'd4;
   localparam logic [3:0] S_E_CHK = 4'd5;
   localparam logic [3:0] S_V_RD  = 4'd6;
   localparam logic [3:0] S_V_MX  = 4'd7;
   localparam logic [3:0] S_V_MY  = 4'd8;
   localparam logic [3:0] S_V_SUM = 4'd9;
   localparam logic [3:0] S_V_CMP = 4'd10;
   localparam logic [3:0] S_SEP   = 4'd11;

   logic [3:0]            state_ff, state_in;
   logic [CNTW-1:0]       count_a_ff, count_a_in;
   logic [CNTW-1:0]       count_b_ff, count_b_in;
   logic                  overflowed_ff, overflowed_in;
   logic [AW-1:0]         edge_ff, edge_in;
   logic                  edge_sel_ff, edge_sel_in;
   logic [AW-1:0]         vert_ff, vert_in;
   logic                  proj_sel_ff, proj_sel_in;
   logic signed [CW-1:0]  xi_ff, xi_in;
   logic signed [CW-1:0]  yi_ff, yi_in;
   logic signed [DW-1:0]  dx_ff, dx_in;
   logic signed [DW-1:0]  dy_ff, dy_in;
   logic signed [W-1:0]   t_ff, t_in;
   logic signed [W-1:0]   u_ff, u_in;
   logic signed [W-1:0]   p_ff, p_in;
   logic signed [W-1:0]   min_a_ff, min_a_in;
   logic signed [W-1:0]   max_a_ff, max_a_in;
   logic signed [W-1:0]   min_b_ff, min_b_in;
   logic signed [W-1:0]   max_b_ff, max_b_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_overlap_ff, rsp_overlap_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  full_a, full_b;
   logic                  wr_a, wr_b, drop;
   logic [CNTW-1:0]       cnt_a_new, cnt_b_new;
   logic                  ovf_new;
   logic [FIELD_BITS+CW-1:0] x_ext, y_ext;
   logic [2*CW-1:0]       wr_word;
   logic [AW-1:0]         rd_addr;
   logic [2*CW-1:0]       rd_a, rd_b, rd_word;
   logic signed [CW-1:0]  rd_x, rd_y;
   logic [CNTW-1:0]       n_edge, n_proj;
   logic                  edge_last, vert_last;
   logic [AW-1:0]         edge_next_idx;
   logic                  edge_next, finish, finish_overlap;
   logic                  separated;
   alu_op_type            alu_op;
   logic signed [W-1:0]   alu_a, alu_b, alu_res;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start & ~busy;

   // vertex store write side
   assign full_a    = (count_a_ff == CNT_MAX);
   assign full_b    = (count_b_ff == CNT_MAX);
   assign wr_a      = accept & ~req_cmd & ~full_a;
   assign wr_b      = accept &  req_cmd & ~full_b;
   assign drop      = accept & ((~req_cmd & full_a) | (req_cmd & full_b));
   assign cnt_a_new = count_a_ff + CNTW'(wr_a);
   assign cnt_b_new = count_b_ff + CNTW'(wr_b);
   assign ovf_new   = overflowed_ff | drop;

   // keep the low coordinate bits; bits above the field read as zero
   assign x_ext   = {{CW{1'b0}}, req_x_coord};
   assign y_ext   = {{CW{1'b0}}, req_y_coord};
   assign wr_word = {x_ext[CW-1:0], y_ext[CW-1:0]};

   cpo_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_a)
   );

   cpo_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_b)
   );

   // edge and vertex indexing
   assign n_edge        = edge_sel_ff ? count_b_ff : count_a_ff;
   assign n_proj        = proj_sel_ff ? count_b_ff : count_a_ff;
   assign edge_last     = (CNTW'(edge_ff) == n_edge - CNTW'(1));
   assign vert_last     = (CNTW'(vert_ff) == n_proj - CNTW'(1));
   assign edge_next_idx = edge_last ? '0 : edge_ff + AW'(1);

   // read address and data select follow the loop in progress
   always_comb begin
      unique case (state_ff) inside
         S_E_RDI:                 rd_addr = edge_ff;
         S_E_RDJ, S_E_DX, S_E_DY: rd_addr = edge_next_idx;
         default:                 rd_addr = vert_ff;
      endcase
   end

   always_comb begin
      unique case (state_ff) inside
         S_E_RDJ, S_E_DX, S_E_DY: rd_word = edge_sel_ff ? rd_b : rd_a;
         default:                 rd_word = proj_sel_ff ? rd_b : rd_a;
      endcase
   end

   assign rd_x = rd_word[2*CW-1:CW];
   assign rd_y = rd_word[CW-1:0];

   // operand steering into the shared unit
   always_comb begin
      unique case (state_ff)
         S_E_DX: begin
            alu_op = ALU_SUB;
            alu_a  = W'(rd_x);
            alu_b  = W'(xi_ff);
         end
         S_E_DY: begin
            alu_op = ALU_SUB;
            alu_a  = W'(rd_y);
            alu_b  = W'(yi_ff);
         end
         S_V_MX: begin
            alu_op = ALU_MUL;
            alu_a  = W'(rd_x);
            alu_b  = W'(dy_ff);
         end
         S_V_MY: begin
            alu_op = ALU_MUL;
            alu_a  = W'(rd_y);
            alu_b  = W'(dx_ff);
         end
         default: begin
            alu_op = ALU_SUB;
            alu_a  = t_ff;
            alu_b  = u_ff;
         end
      endcase
   end

   cpo_alu #(.COORD_BITS(CW)) u_alu (
      .op  (alu_op),
      .opa (alu_a),
      .opb (alu_b),
      .res (alu_res)
   );

   // disjoint projection intervals
   assign separated = (max_a_ff < min_b_ff) || (max_b_ff < min_a_ff);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_a_in     = count_a_ff;
      count_b_in     = count_b_ff;
      overflowed_in  = overflowed_ff;
      edge_in        = edge_ff;
      edge_sel_in    = edge_sel_ff;
      vert_in        = vert_ff;
      proj_sel_in    = proj_sel_ff;
      xi_in          = xi_ff;
      yi_in          = yi_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      t_in           = t_ff;
      u_in           = u_ff;
      p_in           = p_ff;
      min_a_in       = min_a_ff;
      max_a_in       = max_a_ff;
      min_b_in       = min_b_ff;
      max_b_in       = max_b_ff;
      rsp_strobe_in  = 1'b0;
      rsp_overlap_in = rsp_overlap_ff;
      rsp_status_in  = rsp_status_ff;
      edge_next      = 1'b0;
      finish         = 1'b0;
      finish_overlap = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_a_in    = cnt_a_new;
               count_b_in    = cnt_b_new;
               overflowed_in = ovf_new;
               if (req_last) begin
                  if (ovf_new) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_overlap_in = 1'b0;
                     rsp_status_in  = ST_OVERFLOW;
                     count_a_in     = '0;
                     count_b_in     = '0;
                     overflowed_in  = 1'b0;
                  end else if ((cnt_a_new < CNT_MIN) || (cnt_b_new < CNT_MIN)) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_overlap_in = 1'b0;
                     rsp_status_in  = ST_SHORT;
                     count_a_in     = '0;
                     count_b_in     = '0;
                  end else begin
                     edge_in     = '0;
                     edge_sel_in = 1'b0;
                     state_in    = S_E_RDI;
                  end
               end
            end
         end
         S_E_RDI: state_in = S_E_RDJ;
         S_E_RDJ: begin
            xi_in    = rd_x;
            yi_in    = rd_y;
            state_in = S_E_DX;
         end
         S_E_DX: begin
            dx_in    = alu_res[DW-1:0];
            state_in = S_E_DY;
         end
         S_E_DY: begin
            dy_in    = alu_res[DW-1:0];
            state_in = S_E_CHK;
         end
         S_E_CHK: begin
            // a zero-length edge gives no axis
            if ((dx_ff == '0) && (dy_ff == '0)) begin
               edge_next = 1'b1;
            end else begin
               proj_sel_in = 1'b0;
               vert_in     = '0;
               state_in    = S_V_RD;
            end
         end
         S_V_RD: state_in = S_V_MX;
         S_V_MX: begin
            t_in     = alu_res;
            state_in = S_V_MY;
         end
         S_V_MY: begin
            u_in     = alu_res;
            state_in = S_V_SUM;
         end
         S_V_SUM: begin
            p_in     = alu_res;
            state_in = S_V_CMP;
         end
         S_V_CMP: begin
            // fold the projection into the interval of its polygon
            if (proj_sel_ff) begin
               if ((vert_ff == '0) || (p_ff < min_b_ff)) min_b_in = p_ff;
               if ((vert_ff == '0) || (p_ff > max_b_ff)) max_b_in = p_ff;
            end else begin
               if ((vert_ff == '0) || (p_ff < min_a_ff)) min_a_in = p_ff;
               if ((vert_ff == '0) || (p_ff > max_a_ff)) max_a_in = p_ff;
            end
            if (vert_last) begin
               if (proj_sel_ff) begin
                  state_in = S_SEP;
               end else begin
                  proj_sel_in = 1'b1;
                  vert_in     = '0;
                  state_in    = S_V_RD;
               end
            end else begin
               vert_in  = vert_ff + AW'(1);
               state_in = S_V_RD;
            end
         end
         S_SEP: begin
            if (separated) begin
               finish         = 1'b1;
               finish_overlap = 1'b0;
            end else begin
               edge_next = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // advance to the next edge, A first then B
      if (edge_next) begin
         if (edge_last) begin
            if (edge_sel_ff) begin
               finish         = 1'b1;
               finish_overlap = 1'b1;
            end else begin
               edge_sel_in = 1'b1;
               edge_in     = '0;
               state_in    = S_E_RDI;
            end
         end else begin
            edge_in  = edge_next_idx;
            state_in = S_E_RDI;
         end
      end

      // deliver the result and clear the pair
      if (finish) begin
         rsp_strobe_in  = 1'b1;
         rsp_overlap_in = finish_overlap;
         rsp_status_in  = ST_OK;
         count_a_in     = '0;
         count_b_in     = '0;
         overflowed_in  = 1'b0;
         state_in       = S_IDLE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         overflowed_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         overflowed_ff <= overflowed_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      edge_ff        <= edge_in;
      edge_sel_ff    <= edge_sel_in;
      vert_ff        <= vert_in;
      proj_sel_ff    <= proj_sel_in;
      xi_ff          <= xi_in;
      yi_ff          <= yi_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      t_ff           <= t_in;
      u_ff           <= u_in;
      p_ff           <= p_in;
      min_a_ff       <= min_a_in;
      max_a_ff       <= max_a_in;
      min_b_ff       <= min_b_in;
      max_b_ff       <= max_b_in;
      rsp_overlap_ff <= rsp_overlap_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_overlap = rsp_overlap_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// ===== rtl/cpo_ram.sv =====
`timescale 1ns / 1ps

module cpo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cpo_alu.sv =====
`timescale 1ns / 1ps

module cpo_alu #(
   parameter int COORD_BITS = 16
) (
   input  cpo_pkg::alu_op_type              op,
   input  logic signed [2*COORD_BITS+1:0]   opa,
   input  logic signed [2*COORD_BITS+1:0]   opb,
   output logic signed [2*COORD_BITS+1:0]   res
);

   import cpo_pkg::*;

   // edge deltas carry one bit more than a coordinate
   localparam int DW = COORD_BITS + 1;
   localparam int W  = 2 * COORD_BITS + 2;

   logic signed [DW-1:0] mul_a;
   logic signed [DW-1:0] mul_b;
   logic signed [W-1:0]  prod;

   // signed multiply of the narrow operand slices
   assign mul_a = opa[DW-1:0];
   assign mul_b = opb[DW-1:0];
   assign prod  = mul_a * mul_b;

   // one multiplier and one subtractor, picked by op
   always_comb begin
      unique case (op)
         ALU_MUL: res = prod;
         ALU_SUB: res = opa - opb;
         default: res = opa - opb;
      endcase
   end

endmodule
